@@ design/rplc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rplc_pkg;

    localparam int PULSE_W    = 14;
    localparam int TIME_W     = 32;
    localparam int LEVEL_W    = 7;
    localparam int STATE_W    = 6;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [PULSE_W-1:0] RANGE_MIN_RST      = 14'd1019;
    localparam logic [PULSE_W-1:0] RANGE_MAX_RST      = 14'd1981;
    localparam logic [LEVEL_W-1:0] ON_LEVEL_RST       = 7'd20;
    localparam logic [LEVEL_W-1:0] HIGH_LEVEL_RST     = 7'd100;
    localparam logic [TIME_W-1:0]  BLINK_INTERVAL_RST = 32'd400000;

    // divide by three as multiply by 43 and shift by 7, exact below 64
    localparam logic [11:0] DIV3_MUL   = 12'd43;
    localparam int          DIV3_SHIFT = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANGE_MIN      = 3'd0,
        CFG_RANGE_MAX      = 3'd1,
        CFG_ON_LEVEL       = 3'd2,
        CFG_HIGH_LEVEL     = 3'd3,
        CFG_BLINK_INTERVAL = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [PULSE_W-1:0] pulse_us;
        logic [TIME_W-1:0]  now_us;
    } in_t;

    typedef struct packed {
        logic [PULSE_W-1:0] filtered_pulse_us;
        logic [STATE_W-1:0] master_state;
        logic [LEVEL_W-1:0] stop_level;
        logic [LEVEL_W-1:0] reverse_level;
        logic [LEVEL_W-1:0] front_level;
        logic [LEVEL_W-1:0] left_level;
        logic [LEVEL_W-1:0] right_level;
    } out_t;

    typedef struct packed {
        logic [PULSE_W-1:0] range_min_us;
        logic [PULSE_W-1:0] range_max_us;
        logic [LEVEL_W-1:0] on_level;
        logic [LEVEL_W-1:0] high_level;
        logic [TIME_W-1:0]  blink_period_us;
    } cfg_t;

    typedef struct packed {
        logic [PULSE_W-1:0] smoothed_us;
        logic [TIME_W-1:0]  now_us;
    } job_t;

    // bucket to master state: remainder by three low, quotient above
    function automatic logic [STATE_W-1:0] state_of_bucket(input logic [5:0] bucket);
        logic [11:0] prod;
        logic [4:0]  quot;
        logic [5:0]  rem;
        prod = 12'(bucket) * DIV3_MUL;
        quot = prod[DIV3_SHIFT+4:DIV3_SHIFT];
        rem  = bucket - ({1'b0, quot} * 6'd3);
        return {quot[3:0], rem[1:0]};
    endfunction

endpackage

`default_nettype wire

@@ design/rplc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rplc_front #(
    parameter int SMOOTH_DEPTH = 4
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 pulse_valid,
    output logic                pulse_ready,
    input  rplc_pkg::in_t       pulse_data,
    output logic                job_valid,
    input  wire                 job_ready,
    output rplc_pkg::job_t      job_data
);

    localparam int IW = (SMOOTH_DEPTH > 1) ? $clog2(SMOOTH_DEPTH) : 1;

    logic [rplc_pkg::PULSE_W-1:0] ring_reg [SMOOTH_DEPTH];
    logic [IW-1:0]                idx_reg;
    logic [IW-1:0]                idx_next;
    logic [rplc_pkg::PULSE_W-1:0] smooth_reg;
    logic [rplc_pkg::PULSE_W-1:0] smooth_next;
    logic                         match;
    logic                         accept;

    assign pulse_ready = job_ready;
    assign job_valid   = pulse_valid;
    assign accept      = pulse_valid && job_ready;

    // consensus: every other slot already equals the new sample
    always_comb
    begin
        match = 1'b1;
        for (int i = 0; i < SMOOTH_DEPTH; i++)
        begin
            if ((IW'(i) != idx_reg) && (ring_reg[i] != pulse_data.pulse_us))
            begin
                match = 1'b0;
            end
        end
        smooth_next = match ? pulse_data.pulse_us : smooth_reg;
        idx_next    = (idx_reg == IW'(SMOOTH_DEPTH - 1)) ? '0 : idx_reg + 1'b1;
    end

    assign job_data.smoothed_us = smooth_next;
    assign job_data.now_us      = pulse_data.now_us;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SMOOTH_DEPTH; i++)
            begin
                ring_reg[i] <= '0;
            end
            idx_reg    <= '0;
            smooth_reg <= '0;
        end
        else if (accept)
        begin
            ring_reg[idx_reg] <= pulse_data.pulse_us;
            idx_reg           <= idx_next;
            smooth_reg        <= smooth_next;
        end
    end

endmodule

`default_nettype wire

@@ design/rplc_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rplc_queue (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push_valid,
    output logic                push_ready,
    input  rplc_pkg::job_t      push_data,
    output logic                pop_valid,
    input  wire                 pop_ready,
    output rplc_pkg::job_t      pop_data
);

    localparam int PW = $clog2(rplc_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(rplc_pkg::QUEUE_DEPTH + 1);

    rplc_pkg::job_t  mem_reg [rplc_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   head_reg;
    logic [PW-1:0]   tail_reg;
    logic [CW-1:0]   count_reg;
    logic            push;
    logic            pop;

    assign push_ready = (count_reg != CW'(rplc_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[head_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                mem_reg[tail_reg] <= push_data;
                tail_reg <= (tail_reg == PW'(rplc_pkg::QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            end
            if (pop)
            begin
                head_reg <= (head_reg == PW'(rplc_pkg::QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ design/rplc_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rplc_back #(
    parameter int BUCKET_COUNT = 48
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  rplc_pkg::cfg_t      cfg,
    input  wire                 job_valid,
    output logic                job_ready,
    input  rplc_pkg::job_t      job_data,
    output logic                light_valid,
    input  wire                 light_ready,
    output rplc_pkg::out_t      light_data
);

    localparam int KW = $clog2(BUCKET_COUNT);
    localparam int DW = rplc_pkg::PULSE_W + 2;
    localparam int NW = DW + KW;
    localparam int CW = $clog2(KW + 1);
    localparam logic [KW-1:0] BMAX = KW'(BUCKET_COUNT - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SAT,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t                        state_reg, state_next;
    logic                          zero_reg, zero_next;
    logic [NW-1:0]                 rem_reg, rem_next;
    logic [DW-1:0]                 dv_reg, dv_next;
    logic [NW-1:0]                 dvs_reg, dvs_next;
    logic [KW-1:0]                 q_reg, q_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic [rplc_pkg::PULSE_W-1:0]  filt_reg, filt_next;
    logic [rplc_pkg::TIME_W-1:0]   now_reg, now_next;
    logic [rplc_pkg::TIME_W-1:0]   deadline_reg, deadline_next;
    logic                          phase_reg, phase_next;
    logic                          out_valid_reg, out_valid_next;
    rplc_pkg::out_t                out_reg, out_next;

    logic [rplc_pkg::PULSE_W-1:0]  diff;
    logic [rplc_pkg::PULSE_W:0]    span;
    logic [NW-1:0]                 prod;
    logic [KW-1:0]                 bucket;
    logic [rplc_pkg::STATE_W-1:0]  ms;
    logic [1:0]                    mode;
    logic                          ph;

    assign job_ready   = (state_reg == ST_IDLE);
    assign light_valid = out_valid_reg;
    assign light_data  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        zero_next      = zero_reg;
        rem_next       = rem_reg;
        dv_next        = dv_reg;
        dvs_next       = dvs_reg;
        q_next         = q_reg;
        cnt_next       = cnt_reg;
        filt_next      = filt_reg;
        now_next       = now_reg;
        deadline_next  = deadline_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        diff   = job_data.smoothed_us - cfg.range_min_us;
        span   = {1'b0, cfg.range_max_us} - {1'b0, cfg.range_min_us} + 1'b1;
        prod   = NW'(diff) * NW'(BUCKET_COUNT - 1);
        bucket = (q_reg > BMAX) ? BMAX : q_reg;
        ms     = rplc_pkg::state_of_bucket(6'(bucket));
        mode   = ms[3:2];
        ph     = phase_reg;

        if (out_valid_reg && light_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    filt_next  = job_data.smoothed_us;
                    now_next   = job_data.now_us;
                    zero_next  = (cfg.range_max_us < cfg.range_min_us) ||
                                 (job_data.smoothed_us < cfg.range_min_us);
                    rem_next   = (prod << 1) + NW'(span);
                    dv_next    = {span, 1'b0};
                    state_next = ST_SAT;
                end
            end
            ST_SAT:
            begin
                if (zero_reg)
                begin
                    q_next     = '0;
                    state_next = ST_FIN;
                end
                else if (rem_reg >= {dv_reg, {KW{1'b0}}})
                begin
                    q_next     = BMAX;
                    state_next = ST_FIN;
                end
                else
                begin
                    q_next     = '0;
                    dvs_next   = NW'(dv_reg) << (KW - 1);
                    cnt_next   = CW'(KW - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (rem_reg >= dvs_reg)
                begin
                    rem_next = rem_reg - dvs_reg;
                    q_next   = {q_reg[KW-2:0], 1'b1};
                end
                else
                begin
                    q_next = {q_reg[KW-2:0], 1'b0};
                end
                dvs_next = dvs_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || light_ready)
                begin
                    if ((mode != 2'd0) && (deadline_reg < now_reg))
                    begin
                        deadline_next = now_reg + cfg.blink_period_us;
                        ph            = !phase_reg;
                    end
                    phase_next = ph;
                    out_next.filtered_pulse_us = filt_reg;
                    out_next.master_state      = ms;
                    out_next.stop_level    = ms[0] ? cfg.high_level :
                                             (ms[5] ? cfg.on_level : '0);
                    out_next.reverse_level = ms[1] ? cfg.on_level : '0;
                    out_next.front_level   = ms[4] ? cfg.high_level :
                                             (ms[5] ? cfg.on_level : '0);
                    out_next.left_level    = (mode[0] && ph) ? cfg.on_level : '0;
                    out_next.right_level   = (mode[1] && ph) ? cfg.on_level : '0;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            zero_reg      <= 1'b0;
            rem_reg       <= '0;
            dv_reg        <= '0;
            dvs_reg       <= '0;
            q_reg         <= '0;
            cnt_reg       <= '0;
            filt_reg      <= '0;
            now_reg       <= '0;
            deadline_reg  <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            zero_reg      <= zero_next;
            rem_reg       <= rem_next;
            dv_reg        <= dv_next;
            dvs_reg       <= dvs_next;
            q_reg         <= q_next;
            cnt_reg       <= cnt_next;
            filt_reg      <= filt_next;
            now_reg       <= now_next;
            deadline_reg  <= deadline_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

endmodule

`default_nettype wire

@@ design/rc_pulse_light_controller_top.sv @@
// Light controller for an RC receiver channel. Each pulse beat (width and
// microsecond timestamp) passes a consensus filter over the last SMOOTH_DEPTH
// widths, is quantized into BUCKET_COUNT buckets between range_min_us and
// range_max_us, and yields one light beat with the master state and the five
// LED levels. The front filters in the accepting cycle and parks frames in a
// two-entry queue; the back takes one frame at a time and steps it from idle
// through a saturation check and a one-bit-per-cycle restoring divider to a
// finish state that can wait on light_ready; the divider is skipped when the
// bucket is pinned (width below the range, range inverted, or quotient beyond
// the divider's reach). Configuration writes take effect at once and must be
// made while no frame is in flight.
`timescale 1ns / 1ps
`default_nettype none

module rc_pulse_light_controller_top #(
    parameter int SMOOTH_DEPTH = 4,
    parameter int BUCKET_COUNT = 48
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   pulse_valid,
    output logic                                  pulse_ready,
    input  rplc_pkg::in_t                         pulse_data,
    output logic                                  light_valid,
    input  wire                                   light_ready,
    output rplc_pkg::out_t                        light_data,
    input  wire                                   cfg_we,
    input  wire [rplc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire [rplc_pkg::CFG_DATA_W-1:0]        cfg_data
);

    rplc_pkg::cfg_t cfg_reg;
    logic           fq_valid;
    logic           fq_ready;
    rplc_pkg::job_t fq_data;
    logic           qb_valid;
    logic           qb_ready;
    rplc_pkg::job_t qb_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.range_min_us    <= rplc_pkg::RANGE_MIN_RST;
            cfg_reg.range_max_us    <= rplc_pkg::RANGE_MAX_RST;
            cfg_reg.on_level        <= rplc_pkg::ON_LEVEL_RST;
            cfg_reg.high_level      <= rplc_pkg::HIGH_LEVEL_RST;
            cfg_reg.blink_period_us <= rplc_pkg::BLINK_INTERVAL_RST;
        end
        else if (cfg_we)
        begin
            case (rplc_pkg::cfg_idx_t'(cfg_index))
                rplc_pkg::CFG_RANGE_MIN:
                    cfg_reg.range_min_us <= cfg_data[rplc_pkg::PULSE_W-1:0];
                rplc_pkg::CFG_RANGE_MAX:
                    cfg_reg.range_max_us <= cfg_data[rplc_pkg::PULSE_W-1:0];
                rplc_pkg::CFG_ON_LEVEL:
                    cfg_reg.on_level <= cfg_data[rplc_pkg::LEVEL_W-1:0];
                rplc_pkg::CFG_HIGH_LEVEL:
                    cfg_reg.high_level <= cfg_data[rplc_pkg::LEVEL_W-1:0];
                rplc_pkg::CFG_BLINK_INTERVAL:
                    cfg_reg.blink_period_us <= cfg_data[rplc_pkg::TIME_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    rplc_front #(
        .SMOOTH_DEPTH (SMOOTH_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pulse_valid (pulse_valid),
        .pulse_ready (pulse_ready),
        .pulse_data  (pulse_data),
        .job_valid   (fq_valid),
        .job_ready   (fq_ready),
        .job_data    (fq_data)
    );

    rplc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    rplc_back #(
        .BUCKET_COUNT (BUCKET_COUNT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .job_valid   (qb_valid),
        .job_ready   (qb_ready),
        .job_data    (qb_data),
        .light_valid (light_valid),
        .light_ready (light_ready),
        .light_data  (light_data)
    );

endmodule

`default_nettype wire

@@ design/rplc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rplc_checker (
    input wire            clk,
    input wire            rst_n,
    input wire            light_valid,
    input wire            light_ready,
    input rplc_pkg::out_t light_data
);

    // stalled beat stays up
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        light_valid && !light_ready |=> light_valid)
        else $error("light beat dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        light_valid && !light_ready |=> $stable(light_data))
        else $error("light payload changed while stalled");

    // low two state bits are a remainder by three
    a_state_low: assert property (@(posedge clk) disable iff (!rst_n)
        light_valid |-> (light_data.master_state[1:0] != 2'd3))
        else $error("master state low bits out of range");

    a_reverse: assert property (@(posedge clk) disable iff (!rst_n)
        light_valid && !light_data.master_state[1] |-> (light_data.reverse_level == '0))
        else $error("reverse lit without reverse bit");

    a_blink: assert property (@(posedge clk) disable iff (!rst_n)
        light_valid |->
            ((light_data.left_level == '0) || light_data.master_state[2]) &&
            ((light_data.right_level == '0) || light_data.master_state[3]))
        else $error("blinker lit outside its blink mode");

endmodule

bind rc_pulse_light_controller_top rplc_checker u_rplc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .light_valid (light_valid),
    .light_ready (light_ready),
    .light_data  (light_data)
);

`default_nettype wire
